### src/pdd_pkg.sv
`default_nettype none

package pdd_pkg;

   localparam int unsigned CP_BITS    = 21;
   localparam int unsigned NUM_RANGES = 15;

   localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
   localparam logic [15:0] RTL_MIN_BMP  = 16'h0590;
   localparam logic [15:0] UPPER_A      = 16'h0041;
   localparam logic [15:0] UPPER_Z      = 16'h005A;
   localparam logic [15:0] LOWER_A      = 16'h0061;
   localparam logic [15:0] LOWER_Z      = 16'h007A;
   localparam logic [CP_BITS-1:0] SUPP_BASE = 21'h010000;

   localparam logic [CP_BITS-1:0] RTL_LO [NUM_RANGES] = '{
      21'h000590, 21'h000600, 21'h000700, 21'h000750, 21'h000780,
      21'h0007C0, 21'h000800, 21'h000840, 21'h000860, 21'h0008A0,
      21'h00FB1D, 21'h00FB50, 21'h00FE70, 21'h010800, 21'h01E800
   };
   localparam logic [CP_BITS-1:0] RTL_HI [NUM_RANGES] = '{
      21'h0005FF, 21'h0006FF, 21'h00074F, 21'h00077F, 21'h0007BF,
      21'h0007FF, 21'h00083F, 21'h00085F, 21'h00086F, 21'h0008FF,
      21'h00FB4F, 21'h00FDFF, 21'h00FEFF, 21'h010FFF, 21'h01EFFF
   };

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } req_type;

   typedef struct packed {
      logic        direction;
      logic        any_rtl;
      logic [15:0] rtl_total;
      logic [15:0] ltr_total;
   } rsp_type;

   // classification of one code unit against the held surrogate
   typedef struct packed {
      logic       ltr;
      logic       rtl;
      logic       hold_high;
      logic [9:0] high_bits;
   } class_type;

   function automatic logic in_rtl_range(input logic [CP_BITS-1:0] cp);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < NUM_RANGES; k++) begin
         if (cp >= RTL_LO[k] && cp <= RTL_HI[k]) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

### src/pdd_classifier.sv
`default_nettype none

module pdd_classifier (
   input  var pdd_pkg::req_type   item,
   input  wire                    pend_valid,
   input  wire  [9:0]             pend_bits,
   output var pdd_pkg::class_type cls
);

   logic [15:0]                  w;
   logic                         is_low;
   logic                         is_high;
   logic                         is_letter;
   logic                         paired;
   logic [pdd_pkg::CP_BITS-1:0]  supp_cp;
   logic [pdd_pkg::CP_BITS-1:0]  bmp_cp;

   assign w         = item.code_unit;
   assign is_low    = (w >= pdd_pkg::LOW_SURR_LO) && (w <= pdd_pkg::LOW_SURR_HI);
   assign is_high   = (w >= pdd_pkg::HIGH_SURR_LO) && (w <= pdd_pkg::HIGH_SURR_HI);
   assign is_letter = ((w >= pdd_pkg::UPPER_A) && (w <= pdd_pkg::UPPER_Z)) ||
                      ((w >= pdd_pkg::LOWER_A) && (w <= pdd_pkg::LOWER_Z));
   assign paired    = pend_valid && is_low;
   // base plus 20 payload bits; the sum fits in 21 bits, so nothing carries out of bit 20
   assign supp_cp   = pdd_pkg::SUPP_BASE + {1'b0, pend_bits, w[9:0]};
   assign bmp_cp    = {5'd0, w};

   always_comb begin
      cls = '0;
      if (paired) begin
         cls.rtl = pdd_pkg::in_rtl_range(supp_cp);
      end else if (is_letter) begin
         cls.ltr = 1'b1;
      end else if (is_high) begin
         // a high surrogate on the last unit is dropped
         cls.hold_high = !item.last_unit;
         cls.high_bits = w[9:0];
      end else if (w >= pdd_pkg::RTL_MIN_BMP) begin
         cls.rtl = pdd_pkg::in_rtl_range(bmp_cp);
      end
   end

endmodule

`default_nettype wire

### src/paragraph_direction_detector_core.sv
`default_nettype none

// paragraph direction detector
// input channel (req_): one utf-16 code unit per item, last_unit marks the
// final unit of a paragraph. result channel (rsp_): one item per paragraph,
// issued for the item that carries last_unit, with the reading direction,
// an any-rtl flag and the saturated strong-character totals.
// path: an accepted item is held in the input register, processed from there,
// and its result is registered in the result register.
// throughput: one item per cycle unless a last item waits for room in the
// result register; the fifteen range compares run side by side.
// reset clears the counters, the first-strong mark, the held surrogate and
// both stage valids. when the receiver stalls, the result register holds;
// items without last_unit keep flowing, and an item with last_unit waits in
// the input register, which then stops taking new items until the result
// is taken.
module paragraph_direction_detector_core #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  var pdd_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output var pdd_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      FIRST_NONE = 2'd0,
      FIRST_LTR  = 2'd1,
      FIRST_RTL  = 2'd2
   } first_type;

   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   // input register stage
   logic              in_valid_ff, in_valid_in;
   pdd_pkg::req_type  in_item_ff, in_item_in;

   // paragraph state
   logic [COUNT_BITS-1:0] rtl_ff, rtl_in;
   logic [COUNT_BITS-1:0] ltr_ff, ltr_in;
   first_type             first_ff, first_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [9:0]            pend_bits_ff, pend_bits_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   pdd_pkg::rsp_type  out_data_ff, out_data_in;

   pdd_pkg::class_type    cls;
   logic                  stage_go;
   logic                  is_last;
   logic [COUNT_BITS-1:0] rtl_next, ltr_next;
   first_type             first_next;
   logic [15:0]           rtl_total, ltr_total;

   pdd_classifier u_classifier (
      .item       (in_item_ff),
      .pend_valid (pend_valid_ff),
      .pend_bits  (pend_bits_ff),
      .cls        (cls)
   );

   // a last item must find room in the result register
   assign is_last   = in_item_ff.last_unit;
   assign stage_go  = in_valid_ff && !(is_last && out_valid_ff && !rsp_ready);
   assign req_ready = !in_valid_ff || stage_go;

   // saturating counters and first-strong mark after this item
   assign rtl_next = (cls.rtl && !(&rtl_ff)) ? rtl_ff + COUNT_ONE : rtl_ff;
   assign ltr_next = (cls.ltr && !(&ltr_ff)) ? ltr_ff + COUNT_ONE : ltr_ff;

   always_comb begin
      first_next = first_ff;
      if (first_ff == FIRST_NONE) begin
         if (cls.ltr) begin
            first_next = FIRST_LTR;
         end else if (cls.rtl) begin
            first_next = FIRST_RTL;
         end
      end
   end

   // totals are reported on 16 bits, clipped at all ones when the counters are wider
   if (COUNT_BITS > 16) begin : g_clip
      assign rtl_total = (|rtl_next[COUNT_BITS-1:16]) ? 16'hFFFF : rtl_next[15:0];
      assign ltr_total = (|ltr_next[COUNT_BITS-1:16]) ? 16'hFFFF : ltr_next[15:0];
   end else begin : g_extend
      assign rtl_total = 16'(rtl_next);
      assign ltr_total = 16'(ltr_next);
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_item_in  = req_data;
      end
   end

   always_comb begin
      rtl_in        = rtl_ff;
      ltr_in        = ltr_ff;
      first_in      = first_ff;
      pend_valid_in = pend_valid_ff;
      pend_bits_in  = pend_bits_ff;
      if (stage_go) begin
         if (is_last) begin
            // paragraph ends: start the next one clean
            rtl_in        = '0;
            ltr_in        = '0;
            first_in      = FIRST_NONE;
            pend_valid_in = 1'b0;
            pend_bits_in  = '0;
         end else begin
            rtl_in        = rtl_next;
            ltr_in        = ltr_next;
            first_in      = first_next;
            pend_valid_in = cls.hold_high;
            pend_bits_in  = cls.hold_high ? cls.high_bits : 10'd0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_data_in  = out_data_ff;
      if (stage_go && is_last) begin
         out_valid_in = 1'b1;
         // majority wins, a tie goes to whichever strong class came first
         if (rtl_next != ltr_next) begin
            out_data_in.direction = (rtl_next > ltr_next);
         end else begin
            out_data_in.direction = (first_next == FIRST_RTL);
         end
         out_data_in.any_rtl   = (rtl_next != '0);
         out_data_in.rtl_total = rtl_total;
         out_data_in.ltr_total = ltr_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         rtl_ff        <= '0;
         ltr_ff        <= '0;
         first_ff      <= FIRST_NONE;
         pend_valid_ff <= 1'b0;
         pend_bits_ff  <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         rtl_ff        <= rtl_in;
         ltr_ff        <= ltr_in;
         first_ff      <= first_in;
         pend_valid_ff <= pend_valid_in;
         pend_bits_ff  <= pend_bits_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
